@@ rtl/lrrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrrc_pkg
// Shared types, constants and the CRC-32C byte update for the log record
// replay checker.
// ----------------------------------------------------------------------------
package lrrc_pkg;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_item;

    localparam int unsigned AddrW     = 3;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
    localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [31:0] MaxLenReset = 32'd1048576;
    localparam logic [31:0] CrcPoly     = 32'h82F6_3B78;
    localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
    localparam logic [32:0] HdrBytes    = 33'd8;

    localparam logic [1:0] CauseNone = 2'd0;
    localparam logic [1:0] CauseLen  = 2'd1;
    localparam logic [1:0] CauseCrc  = 2'd2;
    localparam logic [1:0] CauseTorn = 2'd3;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/log_record_replay_checker_top.sv @@
// ----------------------------------------------------------------------------
// log_record_replay_checker_top
// Write-ahead log replay checker: length and CRC-32C record deframer with a
// saturating good offset and an APB register for the length limit.
// ----------------------------------------------------------------------------
// An input beat passes through the front register, the four-entry queue,
// then the parser's result register before its result beat appears.
// Throughput is one beat per cycle unless i_ready stalls the output, set by
// the parser's combinational CRC-32C byte update and saturating offset add.
// Synchronous active-low reset clears the parser to the header phase, empties
// the queue and the result register, and sets max_record_len to 1048576.
module log_record_replay_checker_top #(
    parameter int OFFSET_BITS = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_payload_valid,
    output logic                         o_record_accepted,
    output logic [31:0]                  o_record_length,
    output logic                         o_log_stopped,
    output logic [1:0]                   o_stop_cause,
    output logic [OFFSET_BITS-1:0]       o_replay_offset,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrrc_pkg::AddrW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic            w_max_len_wr;
    logic [31:0]     r_max_record_len;
    logic            w_push;
    logic            w_full;
    lrrc_pkg::t_item w_front_item;
    logic            w_q_valid;
    lrrc_pkg::t_item w_q_item;
    logic            w_q_ready;

    assign pready       = 1'b1;
    assign w_max_len_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata       = paddr[2] ? 32'd0 : r_max_record_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record_len <= lrrc_pkg::MaxLenReset;
        end else if (w_max_len_wr) begin
            r_max_record_len <= pwdata;
        end
    end

    lrrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_push      (w_push),
        .o_item      (w_front_item),
        .i_full      (w_full)
    );

    lrrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_q_valid && w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    lrrc_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (w_q_valid),
        .i_item            (w_q_item),
        .o_item_ready      (w_q_ready),
        .i_max_record_len  (r_max_record_len),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_payload_byte    (o_payload_byte),
        .o_payload_valid   (o_payload_valid),
        .o_record_accepted (o_record_accepted),
        .o_record_length   (o_record_length),
        .o_log_stopped     (o_log_stopped),
        .o_stop_cause      (o_stop_cause),
        .o_replay_offset   (o_replay_offset)
    );

    a_cause_only_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_log_stopped |-> o_stop_cause == lrrc_pkg::CauseNone)
        else $error("Stop cause set while the parser is running.");

    a_accept_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_accepted |-> !o_log_stopped)
        else $error("Record accepted on a beat that reports a stop.");

    a_payload_stop_is_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_payload_valid && o_log_stopped |-> o_stop_cause == lrrc_pkg::CauseCrc)
        else $error("Payload byte ended the log with a cause other than CRC mismatch.");

    a_empty_accept_from_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_accepted && !o_payload_valid |-> o_record_length == 32'd0)
        else $error("Record accepted outside its payload with a nonzero length.");

endmodule

@@ rtl/lrrc_front.sv @@
// ----------------------------------------------------------------------------
// lrrc_front
// Input stage: takes log beats, classifies them as data or end of log, and
// hands them to the queue.
// ----------------------------------------------------------------------------
module lrrc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_mode,
    input  logic [7:0]      i_data_byte,
    output logic            o_push,
    output lrrc_pkg::t_item o_item,
    input  logic            i_full
);

    logic            r_valid;
    lrrc_pkg::t_item r_item;
    logic            w_take;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.is_end <= i_mode;
            r_item.data   <= i_mode ? 8'd0 : i_data_byte;
        end
    end

endmodule

@@ rtl/lrrc_fifo.sv @@
// ----------------------------------------------------------------------------
// lrrc_fifo
// Short queue between the front stage and the parser.
// ----------------------------------------------------------------------------
module lrrc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lrrc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lrrc_pkg::t_item o_item
);

    lrrc_pkg::t_item                 r_mem [lrrc_pkg::FifoDepth];
    logic [lrrc_pkg::FifoPtrW-1:0]   r_wr;
    logic [lrrc_pkg::FifoPtrW-1:0]   r_rd;
    logic [lrrc_pkg::FifoCntW-1:0]   r_cnt;

    assign o_full  = (r_cnt == lrrc_pkg::FifoCntW'(lrrc_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/lrrc_back.sv @@
// ----------------------------------------------------------------------------
// lrrc_back
// Record parser: assembles headers, checks lengths, runs the CRC-32C over
// payload bytes, advances the good offset and drives the result register.
// ----------------------------------------------------------------------------
module lrrc_back #(
    parameter int OFFSET_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    input  lrrc_pkg::t_item        i_item,
    output logic                   o_item_ready,
    input  logic [31:0]            i_max_record_len,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_payload_byte,
    output logic                   o_payload_valid,
    output logic                   o_record_accepted,
    output logic [31:0]            o_record_length,
    output logic                   o_log_stopped,
    output logic [1:0]             o_stop_cause,
    output logic [OFFSET_BITS-1:0] o_replay_offset
);

    localparam int SumW = ((OFFSET_BITS > 33) ? OFFSET_BITS : 33) + 1;

    localparam logic [1:0] PhHeader  = 2'd0;
    localparam logic [1:0] PhPayload = 2'd1;
    localparam logic [1:0] PhStopped = 2'd2;

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_hcnt, n_hcnt;
    logic [63:0]            r_hbits, n_hbits;
    logic [31:0]            r_left, n_left;
    logic [31:0]            r_crc, n_crc;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [1:0]             r_cause, n_cause;

    logic                   r_ovalid;
    logic [7:0]             r_pb;
    logic                   r_pv;
    logic                   r_acc;
    logic [31:0]            r_len;
    logic                   r_stop;
    logic [1:0]             r_ocause;
    logic [OFFSET_BITS-1:0] r_ooffset;

    logic                   w_pop;
    logic                   w_pv;
    logic                   w_acc;
    logic [31:0]            w_crc_upd;
    logic [31:0]            w_left_dec;
    logic [31:0]            w_acc_len;
    logic [SumW-1:0]        w_sum;
    logic [OFFSET_BITS-1:0] w_sat_offset;

    assign o_item_ready = !r_ovalid || i_ready;
    assign w_pop        = i_item_valid && o_item_ready;

    assign w_crc_upd    = lrrc_pkg::crc_byte(r_crc, i_item.data);
    assign w_left_dec   = r_left - 32'd1;
    assign w_acc_len    = (r_phase == PhPayload) ? r_hbits[31:0] : 32'd0;
    assign w_sum        = SumW'(r_offset) + SumW'(w_acc_len) + SumW'(lrrc_pkg::HdrBytes);
    assign w_sat_offset = (|w_sum[SumW-1:OFFSET_BITS]) ? {OFFSET_BITS{1'b1}}
                                                        : w_sum[OFFSET_BITS-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_hbits  = r_hbits;
        n_left   = r_left;
        n_crc    = r_crc;
        n_offset = r_offset;
        n_cause  = r_cause;
        w_pv     = 1'b0;
        w_acc    = 1'b0;
        if (r_phase == PhStopped) begin
            n_phase = PhStopped;
        end else if (i_item.is_end) begin
            n_phase = PhStopped;
            n_cause = (r_phase == PhHeader && r_hcnt == 3'd0) ? lrrc_pkg::CauseNone
                                                              : lrrc_pkg::CauseTorn;
        end else begin
            unique case (r_phase)
                PhHeader: begin
                    n_hbits = (r_hcnt == 3'd0) ? 64'd0 : r_hbits;
                    n_hbits[{r_hcnt, 3'b000} +: 8] = i_item.data;
                    n_hcnt = r_hcnt + 3'd1;
                    if (r_hcnt == 3'd7) begin
                        if (n_hbits[31:0] > i_max_record_len) begin
                            n_phase = PhStopped;
                            n_cause = lrrc_pkg::CauseLen;
                        end else if (n_hbits[31:0] == 32'd0) begin
                            if (n_hbits[63:32] == 32'd0) begin
                                w_acc    = 1'b1;
                                n_offset = w_sat_offset;
                            end else begin
                                n_phase = PhStopped;
                                n_cause = lrrc_pkg::CauseCrc;
                            end
                        end else begin
                            n_phase = PhPayload;
                            n_left  = n_hbits[31:0];
                            n_crc   = lrrc_pkg::CrcInit;
                        end
                    end
                end
                PhPayload: begin
                    w_pv   = 1'b1;
                    n_crc  = w_crc_upd;
                    n_left = w_left_dec;
                    if (w_left_dec == 32'd0) begin
                        if (~w_crc_upd == r_hbits[63:32]) begin
                            w_acc    = 1'b1;
                            n_offset = w_sat_offset;
                            n_phase  = PhHeader;
                            n_hcnt   = 3'd0;
                        end else begin
                            n_phase = PhStopped;
                            n_cause = lrrc_pkg::CauseCrc;
                        end
                    end
                end
                default: begin
                    n_phase = PhStopped;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhHeader;
            r_hcnt   <= 3'd0;
            r_hbits  <= 64'd0;
            r_left   <= 32'd0;
            r_crc    <= lrrc_pkg::CrcInit;
            r_offset <= '0;
            r_cause  <= lrrc_pkg::CauseNone;
            r_ovalid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase  <= n_phase;
                r_hcnt   <= n_hcnt;
                r_hbits  <= n_hbits;
                r_left   <= n_left;
                r_crc    <= n_crc;
                r_offset <= n_offset;
                r_cause  <= n_cause;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_pb      <= w_pv ? i_item.data : 8'd0;
            r_pv      <= w_pv;
            r_acc     <= w_acc;
            r_len     <= (n_phase == PhHeader && n_hcnt != 3'd0) ? 32'd0 : n_hbits[31:0];
            r_stop    <= (n_phase == PhStopped);
            r_ocause  <= n_cause;
            r_ooffset <= n_offset;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_payload_byte    = r_pb;
    assign o_payload_valid   = r_pv;
    assign o_record_accepted = r_acc;
    assign o_record_length   = r_len;
    assign o_log_stopped     = r_stop;
    assign o_stop_cause      = r_ocause;
    assign o_replay_offset   = r_ooffset;

endmodule
